/* rtl/rxd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxd_pkg
// Shared types, field widths and the microprogram of the dice roller.
// ----------------------------------------------------------------------------
package rxd_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned SumW   = 24;
  localparam int unsigned RollW  = 25;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned UpcW   = 3;

  localparam logic [0:0] REG_MIX_KEY      = 1'b0;
  localparam logic [0:0] REG_INITIAL_SEED = 1'b1;

  localparam logic [UpcW-1:0] STEP_WAIT  = 3'd0;
  localparam logic [UpcW-1:0] STEP_CHECK = 3'd1;
  localparam logic [UpcW-1:0] STEP_MIX   = 3'd2;
  localparam logic [UpcW-1:0] STEP_DIV   = 3'd3;
  localparam logic [UpcW-1:0] STEP_ACC   = 3'd4;
  localparam logic [UpcW-1:0] STEP_EMIT  = 3'd5;
  localparam logic [UpcW-1:0] STEP_BACK  = 3'd6;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_ZERO_WORK,
    COND_DIV_MORE,
    COND_CNT_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic accept;
    logic mix;
    logic div_step;
    logic acc;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic zero_work;
    logic div_more;
    logic cnt_more;
    logic out_busy;
  } status_t;

  typedef struct packed {
    ctrl_t           ctrl;
    cond_e           cond;
    logic [UpcW-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UpcW-1:0] addr);
    ucode_t w;
    w = '{ctrl: '0, cond: COND_ALWAYS, target: STEP_WAIT};
    unique case (addr)
      STEP_WAIT: begin
        w.ctrl.accept = 1'b1;
        w.cond        = COND_NO_INPUT;
        w.target      = STEP_WAIT;
      end
      STEP_CHECK: begin
        w.cond   = COND_ZERO_WORK;
        w.target = STEP_EMIT;
      end
      STEP_MIX: begin
        w.ctrl.mix = 1'b1;
        w.cond     = COND_ZERO_WORK;
        w.target   = STEP_EMIT;
      end
      STEP_DIV: begin
        w.ctrl.div_step = 1'b1;
        w.cond          = COND_DIV_MORE;
        w.target        = STEP_DIV;
      end
      STEP_ACC: begin
        w.ctrl.acc = 1'b1;
        w.cond     = COND_CNT_MORE;
        w.target   = STEP_MIX;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = COND_OUT_BUSY;
        w.target    = STEP_EMIT;
      end
      STEP_BACK: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/rotate_xor_dice_roller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_xor_dice_roller
// Keyed rotate/XOR dice roller run by a small microprogram.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: req_type; tdata: dice_count, die_sides, offset
//   m_axis    out        tdata: roll_value
//   cfg       in         index 0 mix_key, index 1 initial_seed (loads the word)
//
// A request with nonzero count and sides runs the mix, remainder and accumulate
// steps for each die, then emit and the return to the wait step; a zero count
// or zero sides goes to emit. Draws use the one-bit-per-cycle remainder unit.
// Reset clears the key and the generator word. A result waits in the output
// register; the next item is accepted meanwhile and held at its emit step.
// ----------------------------------------------------------------------------
module rotate_xor_dice_roller
  import rxd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // dice_count[7:0], die_sides[23:8], offset[39:24]
  input  logic [0:0]  s_axis_tuser,  // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // roll_value[24:0], zeros above
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  ctrl_t            ctrl;
  status_t          status;
  logic [RollW-1:0] roll_value;

  rxd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  rxd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .in_valid_i   (s_axis_tvalid),
    .req_type_i   (s_axis_tuser[0]),
    .dice_count_i (s_axis_tdata[7:0]),
    .die_sides_i  (s_axis_tdata[23:8]),
    .offset_i     (s_axis_tdata[39:24]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .roll_value_o (roll_value)
  );

  assign s_axis_tready = ctrl.accept;
  assign m_axis_tdata  = {{(32-RollW){1'b0}}, roll_value};

endmodule

/* rtl/rxd_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxd_seq
// Step counter and microprogram table; jumps to the target when the condition holds, else steps on.
// ----------------------------------------------------------------------------
module rxd_seq
  import rxd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [UpcW-1:0] upc_q, upc_d;
  ucode_t          uw;
  logic            take;

  assign uw     = ucode_rom(upc_q);
  assign ctrl_o = uw.ctrl;

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = ~status_i.in_valid;
      COND_ZERO_WORK: take = status_i.zero_work;
      COND_DIV_MORE:  take = status_i.div_more;
      COND_CNT_MORE:  take = status_i.cnt_more;
      COND_OUT_BUSY:  take = status_i.out_busy;
      default:        take = 1'b1;
    endcase
    upc_d = take ? uw.target : upc_q + UpcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

/* rtl/rxd_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxd_dp
// Datapath: request registers, generator mix, serial remainder unit,
// accumulator and the output register.
// ----------------------------------------------------------------------------
module rxd_dp
  import rxd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  output status_t           status_o,
  input  logic              in_valid_i,
  input  logic              req_type_i,
  input  logic [CountW-1:0] dice_count_i,
  input  logic [WordW-1:0]  die_sides_i,
  input  logic [WordW-1:0]  offset_i,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [WordW-1:0]  cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RollW-1:0]  roll_value_o
);

  logic [WordW-1:0]   key_q, word_q;
  logic               type_q;
  logic [CountW-1:0]  cnt_q;
  logic [WordW-1:0]   sides_q, offset_q;
  logic [WordW-1:0]   rem_q, dvd_q;
  logic [BitCntW-1:0] bits_q;
  logic [SumW-1:0]    sum_q;
  logic               out_valid_q;
  logic [RollW-1:0]   roll_q;

  logic [WordW-1:0]   mix_a, mix_b, mix_x, mix_c, mag;
  logic [WordW:0]     shifted;
  logic [WordW+1:0]   trial;
  logic [RollW-1:0]   total;
  logic               in_take, out_busy;

  assign in_take  = ctrl_i.accept & in_valid_i;
  assign out_busy = out_valid_q & ~out_ready_i;

  assign mix_a = {word_q[WordW-3:0] ^ key_q[WordW-3:0],
                  word_q[WordW-1:WordW-2] ^ key_q[WordW-1:WordW-2]};
  assign mix_b = mix_a + key_q;
  assign mix_x = mix_b ^ word_q;
  assign mix_c = {mix_x[WordW-4:0], mix_x[WordW-1:WordW-3]};
  assign mag   = mix_c[WordW-1] ? (~mix_c + WordW'(1)) : mix_c;

  assign shifted = {rem_q, dvd_q[WordW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, sides_q};

  assign total = {1'b0, sum_q} + {{(RollW-WordW){offset_q[WordW-1]}}, offset_q};

  assign status_o.in_valid  = in_valid_i;
  assign status_o.zero_work = (cnt_q == '0) || (sides_q == '0);
  assign status_o.div_more  = (bits_q != '0);
  assign status_o.cnt_more  = (cnt_q != CountW'(1));
  assign status_o.out_busy  = out_busy;

  assign out_valid_o  = out_valid_q;
  assign roll_value_o = roll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MIX_KEY:      key_q  <= cfg_data_i;
          REG_INITIAL_SEED: word_q <= cfg_data_i;
          default:          ;
        endcase
      end else if (ctrl_i.mix) begin
        word_q <= mag + WordW'(1);
      end
      if (ctrl_i.emit && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      type_q   <= req_type_i;
      cnt_q    <= dice_count_i;
      sides_q  <= die_sides_i;
      offset_q <= offset_i;
      sum_q    <= '0;
    end
    if (ctrl_i.mix) begin
      dvd_q  <= mag;
      rem_q  <= '0;
      bits_q <= BitCntW'(WordW - 1);
    end else if (ctrl_i.div_step) begin
      dvd_q  <= {dvd_q[WordW-2:0], 1'b0};
      bits_q <= bits_q - BitCntW'(1);
      rem_q  <= trial[WordW+1] ? shifted[WordW-1:0] : trial[WordW-1:0];
    end
    if (ctrl_i.acc) begin
      sum_q <= sum_q + SumW'(rem_q) + SumW'(1);
      cnt_q <= cnt_q - CountW'(1);
    end
    if (ctrl_i.emit && !out_busy) begin
      roll_q <= (!type_q && total[RollW-1]) ? '0 : total;
    end
  end

endmodule
